// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the system tick timer
// Request and response word layouts, request kinds, register offsets and
// control bit positions.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Request kinds carried in req_type.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Register byte offsets.
    localparam logic [4:0] OFF_CTRL   = 5'd0;
    localparam logic [4:0] OFF_STATUS = 5'd4;
    localparam logic [4:0] OFF_CNT_LO = 5'd8;
    localparam logic [4:0] OFF_CNT_HI = 5'd12;
    localparam logic [4:0] OFF_CMP_LO = 5'd16;
    localparam logic [4:0] OFF_CMP_HI = 5'd20;

    // Control register bit positions.
    localparam int unsigned CTL_ENABLE_BIT   = 0;
    localparam int unsigned CTL_IRQ_EN_BIT   = 1;
    localparam int unsigned CTL_FROM_CMP_BIT = 4;
    localparam int unsigned CTL_RELOAD_BIT   = 5;
    localparam int unsigned CTL_SWI_BIT      = 31;

    // Status register flag bit.
    localparam int unsigned SR_FLAG_BIT = 0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  reg_offset;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_address;
        logic        tick_irq;
        logic        soft_irq;
    } t_rsp;

endpackage

// ----- rtl/stt_core.sv -----
// ----------------------------------------------------------------------------
// stt_core: register bank and tick counter of the system tick timer
// Holds the timer state, decodes one request word and forms its response.
// ----------------------------------------------------------------------------
module stt_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  stt_pkg::t_req i_req,
    output stt_pkg::t_rsp o_rsp
);
    import stt_pkg::*;

    logic [31:0] r_control, n_control;
    logic        r_status, n_status;
    logic [63:0] r_count, n_count;
    logic [63:0] r_compare, n_compare;
    logic [63:0] r_elapsed, n_elapsed;

    logic [63:0] elapsed_inc;
    logic [31:0] wdata;
    t_rsp        rsp;

    assign elapsed_inc = r_elapsed + 64'd1;
    assign wdata       = i_req.write_data;

    always_comb begin
        n_control = r_control;
        n_status  = r_status;
        n_count   = r_count;
        n_compare = r_compare;
        n_elapsed = r_elapsed;
        rsp       = '0;

        case (i_req.req_type)
            REQ_TICK: begin
                if (r_control[CTL_ENABLE_BIT]) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= r_compare) begin
                        n_elapsed    = '0;
                        n_status     = 1'b1;
                        rsp.tick_irq = r_control[CTL_IRQ_EN_BIT];
                    end
                end
            end
            REQ_READ: begin
                unique case (i_req.reg_offset)
                    OFF_CTRL:   rsp.read_data = r_control;
                    OFF_STATUS: rsp.read_data = {31'd0, r_status};
                    OFF_CNT_LO: rsp.read_data = r_count[31:0];
                    OFF_CNT_HI: rsp.read_data = r_count[63:32];
                    OFF_CMP_LO: rsp.read_data = r_compare[31:0];
                    OFF_CMP_HI: rsp.read_data = r_compare[63:32];
                    default:    rsp.bad_address = 1'b1;
                endcase
            end
            REQ_WRITE: begin
                unique case (i_req.reg_offset)
                    OFF_CTRL: begin
                        n_control = wdata;
                        if (wdata[CTL_RELOAD_BIT]) begin
                            n_count = wdata[CTL_FROM_CMP_BIT] ? r_compare : 64'd0;
                        end
                        rsp.soft_irq = wdata[CTL_SWI_BIT];
                    end
                    OFF_STATUS: begin
                        if (!wdata[SR_FLAG_BIT]) begin
                            n_status = 1'b0;
                        end
                    end
                    OFF_CNT_LO: n_count[31:0]    = wdata;
                    OFF_CNT_HI: n_count[63:32]   = wdata;
                    OFF_CMP_LO: n_compare[31:0]  = wdata;
                    OFF_CMP_HI: n_compare[63:32] = wdata;
                    default:    rsp.bad_address  = 1'b1;
                endcase
            end
            default: begin
                // Unused request kind: no state change, all-zero response.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_status  <= 1'b0;
            r_count   <= '0;
            r_compare <= '0;
            r_elapsed <= '0;
        end else if (i_accept) begin
            r_control <= n_control;
            r_status  <= n_status;
            r_count   <= n_count;
            r_compare <= n_compare;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_rsp = rsp;

    // A tick interrupt always leaves the status flag set.
    a_tick_sets_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && rsp.tick_irq) |=> r_status)
        else $error("tick interrupt without status flag");

    // A software interrupt only comes from a control write with bit 31 set.
    a_swi_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.soft_irq |-> (i_req.req_type == REQ_WRITE && i_req.reg_offset == OFF_CTRL
                          && wdata[CTL_SWI_BIT]))
        else $error("software interrupt from a wrong request");

    // An unmapped access leaves every register untouched.
    a_bad_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && rsp.bad_address) |=>
            ($stable(r_control) && $stable(r_count) && $stable(r_compare)
             && $stable(r_status) && $stable(r_elapsed)))
        else $error("unmapped access changed state");

    // The elapsed count restarts whenever a period elapses.
    a_period_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req.req_type == REQ_TICK && r_control[CTL_ENABLE_BIT]
         && elapsed_inc >= r_compare) |=> (r_elapsed == 64'd0))
        else $error("elapsed count not restarted");

endmodule

// ----- rtl/system_tick_timer_unit.sv -----
// ----------------------------------------------------------------------------
// system_tick_timer_unit: system tick timer with a 32-bit register interface
// A response word is registered: it becomes valid in the cycle after its request is accepted.
// Throughput: one request word per cycle while the receiver keeps taking responses; the
// single output register refills in the same cycle that its word is taken.
// Reset (synchronous, active low) clears the timer registers and the output valid.
// ----------------------------------------------------------------------------
module system_tick_timer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  stt_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output stt_pkg::t_rsp o_rsp
);
    import stt_pkg::*;

    // Each request word is one of: a timer tick, a register read or a
    // register write. Every accepted word yields exactly one response word.
    // The state update and the response are computed in the same cycle the
    // request is accepted; the response sits in r_rsp until it is taken.

    logic r_valid;
    t_rsp r_rsp;
    t_rsp core_rsp;
    logic accept;

    // A new word can enter whenever the output register is empty or is
    // being emptied in this cycle.
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    stt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_rsp    (core_rsp)
    );

    // Output valid: set on acceptance, cleared when taken with nothing new.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Response payload needs no reset; it only loads on acceptance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Every accepted request is followed by a valid response word.
    a_accept_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted request produced no response");

    // An empty output register never blocks the input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output is empty");

    // Read data only appears on responses with no other flag raised.
    a_rsp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.read_data != 32'd0) |->
            (!o_rsp.bad_address && !o_rsp.tick_irq && !o_rsp.soft_irq))
        else $error("read data mixed with other response flags");

endmodule

// ----- bench/tb_system_tick_timer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_system_tick_timer_unit: self-checking bench for the system tick timer
// Drives register reads, register writes and timer ticks through the request
// channel, predicts every response word with a cycle-free timer model, and
// compares each accepted response field by field. Both channels idle at
// random, the receiver stalls for a long stretch, and the sender drains twice.
// ----------------------------------------------------------------------------
module tb_system_tick_timer_unit;

    import stt_pkg::*;

    // The package has no name for the fourth request kind; the block must
    // treat it as a no-op that answers with an all-zero word.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Control register masks built from the package bit positions.
    localparam logic [31:0] CTRL_RUN      = 32'd1 << CTL_ENABLE_BIT;
    localparam logic [31:0] CTRL_IRQ      = 32'd1 << CTL_IRQ_EN_BIT;
    localparam logic [31:0] CTRL_FROM_CMP = 32'd1 << CTL_FROM_CMP_BIT;
    localparam logic [31:0] CTRL_RELOAD   = 32'd1 << CTL_RELOAD_BIT;
    localparam logic [31:0] CTRL_SWI      = 32'd1 << CTL_SWI_BIT;
    localparam logic [31:0] SR_KEEP       = 32'd1 << SR_FLAG_BIT;

    // Unmapped offsets used by the directed checks.
    localparam logic [4:0] OFF_TOP_HOLE = 5'd31;
    localparam logic [4:0] OFF_MISALIGN = 5'd1;

    // Only the first few mismatches are printed; all of them are counted.
    localparam int unsigned PRINT_LIMIT = 40;

    // Every input starts at a known value.
    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_ready = 1'b0;
    t_req  i_req   = '0;
    logic  o_ready;
    logic  o_valid;
    t_rsp  o_rsp;

    system_tick_timer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // Timer model state, kept in step with every accepted request word.
    logic [31:0] tmr_ctrl    = '0;
    logic        tmr_flag    = 1'b0;
    logic [63:0] tmr_count   = '0;
    logic [63:0] tmr_compare = '0;
    logic [63:0] tmr_elapsed = '0;

    // Response words still owed by the block, oldest first.
    t_rsp expected_rsp[$];

    // Idle controls. The sender percentage is only touched by the stimulus
    // process; the receiver controls are written with nonblocking updates
    // so the receiver process always sees a settled value at the edge.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold     = 1'b0;

    int unsigned words_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned tick_irq_seen = 0;
    int unsigned soft_irq_seen = 0;
    int unsigned bad_addr_seen = 0;
    int unsigned mismatch_count = 0;

    always #1 i_clk = ~i_clk;

    // Hard stop far beyond the length of a normal run.
    initial begin
        #400000;
        $display("Timeout: the block stopped making progress.");
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Timer model: returns the response word that one request word causes and
    // advances the model state exactly as the block should.
    // ------------------------------------------------------------------------
    function automatic t_rsp predict_timer(input t_req req);
        t_rsp rsp;
        rsp = '0;
        case (req.req_type)
            REQ_TICK: begin
                // Ticks only count while the timer runs. Reaching compare
                // (or passing it after compare was lowered) ends the period.
                if (tmr_ctrl[CTL_ENABLE_BIT]) begin
                    tmr_elapsed = tmr_elapsed + 64'd1;
                    if (tmr_elapsed >= tmr_compare) begin
                        tmr_elapsed  = '0;
                        tmr_flag     = 1'b1;
                        rsp.tick_irq = tmr_ctrl[CTL_IRQ_EN_BIT];
                    end
                end
            end
            REQ_READ: begin
                case (req.reg_offset)
                    OFF_CTRL:   rsp.read_data = tmr_ctrl;
                    OFF_STATUS: rsp.read_data = {31'b0, tmr_flag};
                    OFF_CNT_LO: rsp.read_data = tmr_count[31:0];
                    OFF_CNT_HI: rsp.read_data = tmr_count[63:32];
                    OFF_CMP_LO: rsp.read_data = tmr_compare[31:0];
                    OFF_CMP_HI: rsp.read_data = tmr_compare[63:32];
                    default:    rsp.bad_address = 1'b1;
                endcase
            end
            REQ_WRITE: begin
                case (req.reg_offset)
                    OFF_CTRL: begin
                        tmr_ctrl = req.write_data;
                        if (req.write_data[CTL_RELOAD_BIT]) begin
                            tmr_count = req.write_data[CTL_FROM_CMP_BIT] ? tmr_compare : '0;
                        end
                        rsp.soft_irq = req.write_data[CTL_SWI_BIT];
                    end
                    OFF_STATUS: begin
                        // Writing a one to the flag bit leaves it alone.
                        if (!req.write_data[SR_FLAG_BIT]) begin
                            tmr_flag = 1'b0;
                        end
                    end
                    OFF_CNT_LO: tmr_count[31:0]    = req.write_data;
                    OFF_CNT_HI: tmr_count[63:32]   = req.write_data;
                    OFF_CMP_LO: tmr_compare[31:0]  = req.write_data;
                    OFF_CMP_HI: tmr_compare[63:32] = req.write_data;
                    default:    rsp.bad_address = 1'b1;
                endcase
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Valid is raised at an edge and held with a stable payload until
    // the block takes the word. After acceptance valid stays high: the caller
    // either sends again in the same time step or calls release_bus.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_req req);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (!o_ready);
        expected_rsp.push_back(predict_timer(req));
        words_sent++;
    endtask

    task automatic bus_op(input logic [1:0] kind, input logic [4:0] offset,
                          input logic [31:0] data);
        send_word(t_req'{kind, offset, data});
    endtask

    task automatic release_bus();
        i_valid <= 1'b0;
    endtask

    // Waits until every response owed has come back, then realigns to an edge.
    task automatic wait_drained();
        release_bus();
        wait (expected_rsp.size() == 0);
        @(posedge i_clk);
    endtask

    // Receiver: ready drops at random, or for a whole stretch while held.
    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold, counted here so the sender keeps running meanwhile.
    task automatic hold_receiver(input int unsigned cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("Mismatch on response %0d: %s got %h expected %h",
                     words_checked, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response checker: every word taken from the block is matched against
    // the oldest prediction, one field at a time.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("response word with nothing outstanding",
                                64'(o_rsp), 64'd0);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.read_data !== want.read_data)
                    report_mismatch("read_data", 64'(o_rsp.read_data),
                                    64'(want.read_data));
                if (o_rsp.bad_address !== want.bad_address)
                    report_mismatch("bad_address", 64'(o_rsp.bad_address),
                                    64'(want.bad_address));
                if (o_rsp.tick_irq !== want.tick_irq)
                    report_mismatch("tick_irq", 64'(o_rsp.tick_irq),
                                    64'(want.tick_irq));
                if (o_rsp.soft_irq !== want.soft_irq)
                    report_mismatch("soft_irq", 64'(o_rsp.soft_irq),
                                    64'(want.soft_irq));
                tick_irq_seen += 32'(want.tick_irq);
                soft_irq_seen += 32'(want.soft_irq);
                bad_addr_seen += 32'(want.bad_address);
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Random request word. Ticks dominate and compare is mostly kept small so
    // that periods elapse often; offsets are mostly mapped, with a share of
    // arbitrary ones, and a few words carry the unused request kind.
    // ------------------------------------------------------------------------
    function automatic t_req random_request();
        t_req        req;
        int unsigned pick;
        req.write_data = $urandom;
        pick = $urandom_range(99);
        if (pick < 3)       req.req_type = REQ_UNUSED;
        else if (pick < 50) req.req_type = REQ_TICK;
        else if (pick < 72) req.req_type = REQ_READ;
        else                req.req_type = REQ_WRITE;

        if ($urandom_range(99) < 12) begin
            req.reg_offset = 5'($urandom_range(31));
        end else begin
            case ($urandom_range(5))
                0:       req.reg_offset = OFF_CTRL;
                1:       req.reg_offset = OFF_STATUS;
                2:       req.reg_offset = OFF_CNT_LO;
                3:       req.reg_offset = OFF_CNT_HI;
                4:       req.reg_offset = OFF_CMP_LO;
                default: req.reg_offset = OFF_CMP_HI;
            endcase
        end

        if (req.req_type == REQ_WRITE) begin
            case (req.reg_offset)
                OFF_CTRL: begin
                    // Keep the timer running and the interrupt enabled most
                    // of the time; reload and soft interrupt stay random.
                    req.write_data[CTL_ENABLE_BIT] = ($urandom_range(99) < 80);
                    req.write_data[CTL_IRQ_EN_BIT] = ($urandom_range(99) < 70);
                end
                OFF_CMP_LO: if ($urandom_range(99) < 80) req.write_data = $urandom_range(12);
                OFF_CMP_HI: if ($urandom_range(99) < 85) req.write_data = '0;
                default: ;
            endcase
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Test: register access after reset, word halves, reload from compare or
    // to zero, the software interrupt, unmapped offsets and the unused kind.
    // ------------------------------------------------------------------------
    task automatic test_register_access();
        bus_op(REQ_READ,  OFF_CTRL,   32'h0);
        bus_op(REQ_WRITE, OFF_CNT_LO, 32'hFFFF_FFFF);
        bus_op(REQ_WRITE, OFF_CNT_HI, 32'hFFFF_FFFF);
        bus_op(REQ_READ,  OFF_CNT_HI, 32'h0);
        bus_op(REQ_WRITE, OFF_CMP_HI, 32'hA5A5_5A5A);
        bus_op(REQ_WRITE, OFF_CMP_LO, 32'hFFFF_FFFF);
        // Reload count from compare, then read back the upper word.
        bus_op(REQ_WRITE, OFF_CTRL,   CTRL_RELOAD | CTRL_FROM_CMP);
        bus_op(REQ_READ,  OFF_CNT_HI, 32'h0);
        // Reload to zero together with a software interrupt.
        bus_op(REQ_WRITE, OFF_CTRL,   CTRL_RELOAD | CTRL_SWI);
        bus_op(REQ_READ,  OFF_CNT_LO, 32'h0);
        bus_op(REQ_WRITE, OFF_TOP_HOLE, 32'hFFFF_FFFF);
        bus_op(REQ_READ,  OFF_MISALIGN, 32'h0);
        bus_op(REQ_UNUSED, OFF_TOP_HOLE, 32'hFFFF_FFFF);
    endtask

    // ------------------------------------------------------------------------
    // Test: tick behavior. A tick while stopped, a compare of zero and of one,
    // the status flag kept by a one and cleared by a zero, a compare lowered
    // below the elapsed count, and a period with the interrupt disabled.
    // ------------------------------------------------------------------------
    task automatic test_tick_period();
        bus_op(REQ_WRITE, OFF_CMP_HI, 32'h0);
        bus_op(REQ_WRITE, OFF_CMP_LO, 32'h0);
        bus_op(REQ_TICK,  OFF_CTRL,   32'h0);
        bus_op(REQ_WRITE, OFF_CTRL,   CTRL_RUN | CTRL_IRQ);
        bus_op(REQ_TICK,  OFF_CTRL,   32'h0);
        bus_op(REQ_WRITE, OFF_STATUS, SR_KEEP);
        bus_op(REQ_READ,  OFF_STATUS, 32'h0);
        bus_op(REQ_WRITE, OFF_STATUS, 32'h0);
        bus_op(REQ_WRITE, OFF_CMP_LO, 32'd3);
        bus_op(REQ_TICK,  OFF_CTRL,   32'h0);
        bus_op(REQ_TICK,  OFF_CTRL,   32'h0);
        // Elapsed is now above the new compare; the next tick must fire.
        bus_op(REQ_WRITE, OFF_CMP_LO, 32'd1);
        bus_op(REQ_TICK,  OFF_CTRL,   32'h0);
        bus_op(REQ_WRITE, OFF_CTRL,   CTRL_RUN);
        bus_op(REQ_TICK,  OFF_CTRL,   32'h0);
    endtask

    // Test: random traffic with the given idle rates on each side.
    task automatic test_random_traffic(input int unsigned words,
                                       input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        int unsigned n;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        for (n = 0; n < words; n++) send_word(random_request());
    endtask

    // Test: the receiver holds off for a long stretch while the sender keeps
    // offering words, so the output register fills and input ready drops.
    task automatic test_receiver_stall();
        int unsigned n;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        fork
            hold_receiver(200);
        join_none
        for (n = 0; n < 60; n++) send_word(random_request());
    endtask

    // Test: the sender pauses until every outstanding response has arrived.
    task automatic test_sender_drain();
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_tick_period();
        test_random_traffic(480, 30, 64);
        test_sender_drain();
        test_random_traffic(480, 64, 30);
        test_receiver_stall();
        test_random_traffic(480, 0, 0);

        // Let the last response pass through the output register.
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d request words (ticks, reads, writes, unmapped and unused kinds).",
                 words_sent);
        $display("Checked %0d responses: %0d tick irqs, %0d soft irqs, %0d bad addresses.",
                 words_checked, tick_irq_seen, soft_irq_seen, bad_addr_seen);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
